// File: hw/rtl/hrle_pkg.sv
// Shared types, character codes and hex formatting helpers for the
// hex record line encoder. Used by hrle_track, hrle_serial and the top level.
package hrle_pkg;

	// Request opcode carried on the op field
	typedef enum logic {
		OP_BEGIN = 1'b0,
		OP_DATA  = 1'b1
	} op_t;

	// ASCII codes of the record line
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	// Character positions inside a begin request (header, then optional close)
	localparam logic [3:0] BEG_COLON    = 4'd0;
	localparam logic [3:0] BEG_CNT_HI   = 4'd1;
	localparam logic [3:0] BEG_CNT_LO   = 4'd2;
	localparam logic [3:0] BEG_AH_HI    = 4'd3;
	localparam logic [3:0] BEG_AH_LO    = 4'd4;
	localparam logic [3:0] BEG_AL_HI    = 4'd5;
	localparam logic [3:0] BEG_AL_LO    = 4'd6;
	localparam logic [3:0] BEG_TYPE_HI  = 4'd7;
	localparam logic [3:0] BEG_TYPE_LO  = 4'd8;
	localparam logic [3:0] BEG_CHK_HI   = 4'd9;
	localparam logic [3:0] BEG_CHK_LO   = 4'd10;
	localparam logic [3:0] BEG_NEWLINE  = 4'd11;

	// Character positions inside a data request
	localparam logic [3:0] DAT_BYTE_HI  = 4'd0;
	localparam logic [3:0] DAT_BYTE_LO  = 4'd1;
	localparam logic [3:0] DAT_CHK_HI   = 4'd2;
	localparam logic [3:0] DAT_CHK_LO   = 4'd3;
	localparam logic [3:0] DAT_NEWLINE  = 4'd4;

	// Everything the serializer needs to spell out one request
	typedef struct packed {
		logic       is_begin;
		logic       close;
		logic [7:0] value;   // byte count for a begin, payload byte for data
		logic [7:0] addr_hi;
		logic [7:0] addr_lo;
		logic [7:0] check;
	} desc_t;

	// Serializer status seen by the top level
	typedef struct packed {
		logic       busy;
		logic [3:0] idx;
	} ser_stat_t;

	function automatic logic [7:0] nibble_char(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = 8'(CH_ZERO + {4'b0, n});
		end else begin
			r = 8'(CH_UPPER_A + {4'b0, n} - 8'd10);
		end
		return r;
	endfunction

	function automatic logic [3:0] last_idx(input desc_t d);
		logic [3:0] r;
		if (d.is_begin) begin
			r = d.close ? BEG_NEWLINE : BEG_TYPE_LO;
		end else begin
			r = d.close ? DAT_NEWLINE : DAT_BYTE_LO;
		end
		return r;
	endfunction

	function automatic logic [7:0] char_at(input desc_t d, input logic [3:0] idx);
		logic [7:0] c;
		c = CH_NEWLINE;
		if (d.is_begin) begin
			unique case (idx)
				BEG_COLON:   c = CH_COLON;
				BEG_CNT_HI:  c = nibble_char(d.value[7:4]);
				BEG_CNT_LO:  c = nibble_char(d.value[3:0]);
				BEG_AH_HI:   c = nibble_char(d.addr_hi[7:4]);
				BEG_AH_LO:   c = nibble_char(d.addr_hi[3:0]);
				BEG_AL_HI:   c = nibble_char(d.addr_lo[7:4]);
				BEG_AL_LO:   c = nibble_char(d.addr_lo[3:0]);
				BEG_TYPE_HI: c = CH_ZERO;
				BEG_TYPE_LO: c = CH_ZERO;
				BEG_CHK_HI:  c = nibble_char(d.check[7:4]);
				BEG_CHK_LO:  c = nibble_char(d.check[3:0]);
				default:     c = CH_NEWLINE;
			endcase
		end else begin
			unique case (idx)
				DAT_BYTE_HI: c = nibble_char(d.value[7:4]);
				DAT_BYTE_LO: c = nibble_char(d.value[3:0]);
				DAT_CHK_HI:  c = nibble_char(d.check[7:4]);
				DAT_CHK_LO:  c = nibble_char(d.check[3:0]);
				default:     c = CH_NEWLINE;
			endcase
		end
		return c;
	endfunction

endpackage

// File: hw/rtl/hrle_track.sv
// Record tracking and input register stage of the hex record line encoder.
// Keeps open/bytes-left/checksum state and builds a line descriptor; uses hrle_pkg.
module hrle_track (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              op,
	input  logic [15:0]       load_address,
	input  logic [7:0]        byte_count,
	input  logic [7:0]        data_byte,
	input  logic              take,
	output logic              s1_valid,
	output hrle_pkg::desc_t   desc_s1
);

	logic            open_q;
	logic [7:0]      left_q;
	logic [7:0]      sum_q;
	logic            s1_valid_q;
	logic            accept;
	logic            is_begin;
	logic            keep;
	logic [7:0]      sum_new;
	hrle_pkg::desc_t desc_new;

	// Stall while the stage holds a request the serializer has not taken
	assign item_stall = s1_valid_q && !take;
	assign accept     = item_valid && !item_stall;
	assign s1_valid   = s1_valid_q;

	// Build the descriptor and the running checksum
	always_comb begin
		is_begin = (op == hrle_pkg::OP_BEGIN);
		keep     = is_begin || open_q;
		if (is_begin) begin
			sum_new = 8'(byte_count + load_address[15:8] + load_address[7:0]);
		end else begin
			sum_new = 8'(sum_q + data_byte);
		end
		desc_new.is_begin = is_begin;
		desc_new.close    = is_begin ? (byte_count == 8'd0) : (left_q == 8'd1);
		desc_new.value    = is_begin ? byte_count : data_byte;
		desc_new.addr_hi  = load_address[15:8];
		desc_new.addr_lo  = load_address[7:0];
		desc_new.check    = 8'(8'd0 - sum_new);
	end

	// Advance record state on every request that is not dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			left_q <= 8'd0;
			sum_q  <= 8'd0;
		end else if (accept && keep) begin
			if (desc_new.close) begin
				open_q <= 1'b0;
				left_q <= 8'd0;
				sum_q  <= 8'd0;
			end else begin
				open_q <= 1'b1;
				left_q <= is_begin ? byte_count : 8'(left_q - 8'd1);
				sum_q  <= sum_new;
			end
		end
	end

	// Hold the descriptor until the serializer takes it; drop orphan data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			if (take) begin
				s1_valid_q <= 1'b0;
			end
			if (accept) begin
				s1_valid_q <= keep;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			desc_s1 <= desc_new;
		end
	end

endmodule

// File: hw/rtl/hrle_serial.sv
// Character serializer and output register of the hex record line encoder.
// Walks a descriptor a char per cycle unless stalled; uses hrle_pkg formatting.
module hrle_serial (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s1_valid,
	input  hrle_pkg::desc_t     desc_s1,
	output logic                take,
	output logic                char_valid,
	input  logic                char_stall,
	output logic [7:0]          out_char,
	output logic                line_end,
	output hrle_pkg::ser_stat_t stat
);

	logic            busy_q;
	logic [3:0]      idx_q;
	hrle_pkg::desc_t desc_q;
	logic            char_valid_q;
	logic            load_out;
	logic            emit;
	logic            at_last;

	// Emit a character whenever the output register is free or draining
	assign load_out   = !char_valid_q || !char_stall;
	assign emit       = busy_q && load_out;
	assign at_last    = (idx_q == hrle_pkg::last_idx(desc_q));
	assign take       = s1_valid && (!busy_q || (emit && at_last));
	assign char_valid = char_valid_q;
	assign stat.busy  = busy_q;
	assign stat.idx   = idx_q;

	// Advance through the characters of the current request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 4'd0;
		end else if (take) begin
			busy_q <= 1'b1;
			idx_q  <= 4'd0;
		end else if (emit && at_last) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			idx_q <= 4'(idx_q + 4'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			desc_q <= desc_s1;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_q <= 1'b0;
		end else if (emit) begin
			char_valid_q <= 1'b1;
		end else if (!char_stall) begin
			char_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_char <= hrle_pkg::char_at(desc_q, idx_q);
			line_end <= at_last && desc_q.close;
		end
	end

endmodule

// File: hw/rtl/hex_record_line_encoder.sv
// Hex record line encoder top level: type 00 records as ASCII characters.
// A request passes the input register, the serializer descriptor register and
// the output register. One character per cycle while char_stall is low; a data
// request spells 2 characters (5 when it closes the line), a begin request 9
// (12 for a zero count). The input stage holds one request behind the serializer.
// Reset clears the open record, checksum and all valid flags; payload is not reset.
module hex_record_line_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        op,
	input  logic [15:0] load_address,
	input  logic [7:0]  byte_count,
	input  logic [7:0]  data_byte,
	output logic        char_valid,
	input  logic        char_stall,
	output logic [7:0]  out_char,
	output logic        line_end
);

	logic                s1_valid;
	logic                take;
	hrle_pkg::desc_t     desc_s1;
	hrle_pkg::ser_stat_t stat;

	// Record state and input stage
	hrle_track u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.op           (op),
		.load_address (load_address),
		.byte_count   (byte_count),
		.data_byte    (data_byte),
		.take         (take),
		.s1_valid     (s1_valid),
		.desc_s1      (desc_s1)
	);

	// Character serializer and output register
	hrle_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1_valid   (s1_valid),
		.desc_s1    (desc_s1),
		.take       (take),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.out_char   (out_char),
		.line_end   (line_end),
		.stat       (stat)
	);

	// The closing mark rides only on a newline
	a_line_end_newline: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && line_end |-> out_char == hrle_pkg::CH_NEWLINE)
		else $error("line_end set on a character other than newline");

	// The character index never runs past the longest line
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> stat.idx <= hrle_pkg::BEG_NEWLINE)
		else $error("serializer index out of range");

	// An idle serializer picks up a waiting request at once
	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !stat.busy |-> take)
		else $error("waiting request not handed to idle serializer");

	// A stall on the input side always has a request waiting behind it
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> s1_valid && stat.busy)
		else $error("input stalled with nothing pending");

endmodule

// File: sim/hex_record_line_encoder_test.sv
// Self-checking testbench for hex_record_line_encoder: drives begin and data requests,
// predicts every ASCII character of each record line and checks them in order.
// Depends on hrle_pkg (opcode enum, character codes) and the encoder RTL.
`timescale 1ns / 100ps

module hex_record_line_encoder_test;

	// Record line predictor and store of expected characters
	class hex_line_scoreboard;
		typedef struct {
			logic [7:0] ch;
			logic       last;
		} line_char_t;

		line_char_t expected_chars[$];
		bit         rec_open;
		bit [7:0]   bytes_left;
		bit [7:0]   running_sum;
		int         errors;

		function int pending();
			return expected_chars.size();
		endfunction

		task report(string msg);
			$display("%0t ns mismatch: %s", $time, msg);
			errors++;
		endtask

		function bit [7:0] hex_digit(bit [3:0] n);
			return (n < 4'd10) ? hrle_pkg::CH_ZERO + 8'(n)
				: hrle_pkg::CH_UPPER_A + 8'(n) - 8'd10;
		endfunction

		function void push_char(bit [7:0] c, bit last);
			line_char_t e;
			e.ch = c;
			e.last = last;
			expected_chars.push_back(e);
		endfunction

		function void push_hex(bit [7:0] b);
			push_char(hex_digit(b[7:4]), 1'b0);
			push_char(hex_digit(b[3:0]), 1'b0);
		endfunction

		// Append checksum and newline, then close the record
		function void push_closing();
			push_hex(8'(8'd0 - running_sum));
			push_char(hrle_pkg::CH_NEWLINE, 1'b1);
			rec_open = 1'b0;
			bytes_left = '0;
			running_sum = '0;
		endfunction

		// Predict the characters of one accepted request; return how many
		function int note_request(hrle_pkg::op_t o, bit [15:0] addr, bit [7:0] cnt,
			bit [7:0] data);
			int before_n;
			before_n = expected_chars.size();
			if (o == hrle_pkg::OP_BEGIN) begin
				push_char(hrle_pkg::CH_COLON, 1'b0);
				push_hex(cnt);
				push_hex(addr[15:8]);
				push_hex(addr[7:0]);
				push_hex(8'h00);
				running_sum = 8'(cnt + addr[15:8] + addr[7:0]);
				bytes_left = cnt;
				rec_open = 1'b1;
				if (cnt == 8'd0)
					push_closing();
			end else if (rec_open) begin
				push_hex(data);
				running_sum = running_sum + data;
				bytes_left = bytes_left - 8'd1;
				if (bytes_left == 8'd0)
					push_closing();
			end
			return expected_chars.size() - before_n;
		endfunction

		// Compare one accepted character with the oldest expectation
		task check_char(logic [7:0] ch, logic last);
			line_char_t e;
			if (expected_chars.size() == 0) begin
				report($sformatf("char 8'h%02h with nothing expected", ch));
			end else begin
				e = expected_chars.pop_front();
				if (ch !== e.ch)
					report($sformatf("out_char 8'h%02h, expected 8'h%02h", ch, e.ch));
				if (last !== e.last)
					report($sformatf("line_end %b, expected %b", last, e.last));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic        op;
	logic [15:0] load_address;
	logic [7:0]  byte_count;
	logic [7:0]  data_byte;
	logic        char_valid;
	logic        char_stall;
	logic [7:0]  out_char;
	logic        line_end;

	hex_line_scoreboard sb;
	int tx_gap_max;
	int rx_gap_max;
	int rx_hold_cycles;
	int useful_requests;

	hex_record_line_encoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.op           (op),
		.load_address (load_address),
		.byte_count   (byte_count),
		.data_byte    (data_byte),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.out_char     (out_char),
		.line_end     (line_end)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Offer one request after a random gap and hold it until accepted
	task automatic send_request(hrle_pkg::op_t o, bit [15:0] addr, bit [7:0] cnt,
		bit [7:0] data);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		op <= o;
		load_address <= addr;
		byte_count <= cnt;
		data_byte <= data;
		do @(posedge clk); while (item_stall);
		if (sb.note_request(o, addr, cnt, data) > 0 || o == hrle_pkg::OP_BEGIN)
			useful_requests++;
	endtask

	// Send one record with random content; sometimes cut it short or add a stray byte
	task automatic send_random_record();
		int pick;
		int n;
		int sent;
		pick = $urandom_range(0, 99);
		if (pick < 2)
			n = 255;
		else if (pick < 70)
			n = $urandom_range(0, 6);
		else
			n = $urandom_range(7, 32);
		if (n > 300 - useful_requests)
			n = 300 - useful_requests;
		sent = n;
		if (n > 0 && $urandom_range(0, 9) == 0)
			sent = $urandom_range(0, n - 1);
		tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
		rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
		send_request(hrle_pkg::OP_BEGIN, 16'($urandom), 8'(n), 8'($urandom));
		for (int i = 0; i < sent; i++)
			send_request(hrle_pkg::OP_DATA, 16'($urandom), 8'($urandom), 8'($urandom));
		if ($urandom_range(0, 9) == 0)
			send_request(hrle_pkg::OP_DATA, 16'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Drop valid, wait until every predicted character has arrived, then settle
	task automatic wait_drain(int limit);
		int n;
		n = 0;
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending() > 0 && n < limit) begin
			@(posedge clk);
			n++;
		end
		repeat (16) @(posedge clk);
	endtask

	// Receiver: stall a random number of cycles, or the set hold, before each character
	initial begin
		int w;
		char_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_cycles > 0) begin
				w = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else begin
				w = $urandom_range(0, rx_gap_max);
			end
			@(negedge clk);
			if (w > 0) begin
				char_stall <= 1'b1;
				repeat (w) @(negedge clk);
			end
			char_stall <= 1'b0;
			do @(posedge clk); while (!char_valid);
		end
	end

	// Check every accepted character
	always @(posedge clk) begin
		if (arst_n && char_valid && !char_stall)
			sb.check_char(out_char, line_end);
	end

	// Stimulus
	initial begin
		sb = new();
		tx_gap_max = 12;
		rx_gap_max = 12;
		rx_hold_cycles = 0;
		useful_requests = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		op = hrle_pkg::OP_BEGIN;
		load_address = '0;
		byte_count = '0;
		data_byte = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: stray byte, zero counts, extremes, abandoned records
		send_request(hrle_pkg::OP_DATA, 16'hFFFF, 8'hFF, 8'h3C);
		send_request(hrle_pkg::OP_BEGIN, 16'h0000, 8'h00, 8'hFF);
		send_request(hrle_pkg::OP_BEGIN, 16'hFFFF, 8'h00, 8'h00);
		send_request(hrle_pkg::OP_BEGIN, 16'h1234, 8'h02, 8'h00);
		send_request(hrle_pkg::OP_DATA, 16'h0000, 8'h00, 8'h00);
		send_request(hrle_pkg::OP_DATA, 16'hFFFF, 8'hFF, 8'hFF);
		send_request(hrle_pkg::OP_DATA, 16'h5555, 8'h55, 8'h77);
		send_request(hrle_pkg::OP_BEGIN, 16'hABCD, 8'h03, 8'h11);
		send_request(hrle_pkg::OP_DATA, 16'h0000, 8'h00, 8'h5A);
		send_request(hrle_pkg::OP_BEGIN, 16'hFEDC, 8'h01, 8'h22);
		send_request(hrle_pkg::OP_DATA, 16'h0000, 8'h00, 8'hA5);
		send_request(hrle_pkg::OP_BEGIN, 16'h0F0F, 8'hFF, 8'h33);
		send_request(hrle_pkg::OP_DATA, 16'h0000, 8'h00, 8'h01);
		send_request(hrle_pkg::OP_DATA, 16'h0000, 8'h00, 8'h89);
		send_request(hrle_pkg::OP_BEGIN, 16'hF0F0, 8'h01, 8'h44);
		send_request(hrle_pkg::OP_DATA, 16'h0000, 8'h00, 8'hC3);
		send_request(hrle_pkg::OP_BEGIN, 16'h8000, 8'h01, 8'h66);
		send_request(hrle_pkg::OP_DATA, 16'h7FFF, 8'h80, 8'h9E);

		// Pause the sender until the line is drained
		wait_drain(20000);

		// Hold the receiver off while the sender streams a full record
		tx_gap_max = 0;
		rx_gap_max = 0;
		rx_hold_cycles = 200;
		send_request(hrle_pkg::OP_BEGIN, 16'h2468, 8'd30, 8'($urandom));
		for (int i = 0; i < 30; i++)
			send_request(hrle_pkg::OP_DATA, 16'($urandom), 8'($urandom), 8'($urandom));
		wait_drain(20000);

		// Random records
		useful_requests = 0;
		while (useful_requests < 300)
			send_random_record();
		@(negedge clk);
		item_valid <= 1'b0;

		wait_drain(20000);
		if (sb.pending() > 0)
			sb.report($sformatf("%0d expected chars never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("hex_record_line_encoder_test: done, clean");
		end else begin
			$display("hex_record_line_encoder_test: done, errors");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("hex_record_line_encoder_test: done, errors");
		$finish;
	end

endmodule

// File: hex_record_line_encoder.f
hw/rtl/hrle_pkg.sv
hw/rtl/hrle_track.sv
hw/rtl/hrle_serial.sv
hw/rtl/hex_record_line_encoder.sv
sim/hex_record_line_encoder_test.sv
